### rtl/button_tap_double_long_classifier_unit_defines.svh
// Assertion macros for the button classifier
`ifndef BUTTON_TAP_DOUBLE_LONG_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_TAP_DOUBLE_LONG_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define BDLC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdlc assertion failed");
`define BDLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdlc assertion failed");
`else
`define BDLC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BDLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/bdlc_pkg.sv
package bdlc_pkg;

   localparam int unsigned CNT_W      = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned LVL_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [CNT_W-1:0] LONG_PRESS_RESET   = 16'd600;
   localparam logic [CNT_W-1:0] DOUBLE_WINDOW_RESET = 16'd400;
   localparam logic [CNT_W-1:0] CNT_MAX            = '1;

   typedef enum logic [1:0] {
      CMD_PLAY_PAUSE = 2'd0,
      CMD_NEXT       = 2'd1,
      CMD_PREVIOUS   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LONG_PRESS    = 1'b0,
      REG_DOUBLE_WINDOW = 1'b1
   } csr_idx_type;

   typedef struct packed {
      cmd_type cmd;
      logic    last;
   } entry_type;

   typedef struct packed {
      logic [1:0] count;
      entry_type  first;
      entry_type  second;
      logic       emit_pp;
      logic       emit_next;
      logic       emit_prev;
   } tick_res_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             has_room;
   } fifo_stat_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

### rtl/button_tap_double_long_classifier_unit.sv
// A tick's results are queued at its transaction, so rsp_valid is high next cycle.
// Throughput: one tick per cycle; results leave one per cycle while rsp_ready
// is high; input stalls only while more than two wait in the four-entry queue.
// Reset: synchronous, active high; timers, flags and queue clear, registers
// return to 600 and 400.
`include "button_tap_double_long_classifier_unit_defines.svh"

module button_tap_double_long_classifier_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_button_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_command,
   output logic                           rsp_last_of_tick,
   input  logic                           csr_we,
   input  logic [bdlc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdlc_pkg::CNT_W-1:0]     csr_wdata
);

   logic                    accept;
   bdlc_pkg::tick_res_type  res;
   bdlc_pkg::entry_type     head;
   bdlc_pkg::fifo_stat_type stat;

   assign req_ready = stat.has_room;
   assign accept    = req_valid & req_ready;

   bdlc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .button_level (req_button_level),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .res          (res)
   );

   bdlc_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .res        (res),
      .pop        (rsp_ready),
      .head       (head),
      .head_valid (rsp_valid),
      .stat       (stat)
   );

   assign rsp_command      = head.cmd;
   assign rsp_last_of_tick = head.last;

   `BDLC_ASSERT_IMPL(a_level_bound, clock, reset, 1'b1, stat.level <= bdlc_pkg::FIFO_DEPTH)
   `BDLC_ASSERT_IMPL(a_next_pp_excl, clock, reset, accept, !(res.emit_next && res.emit_pp))
   `BDLC_ASSERT_IMPL(a_prev_held, clock, reset, accept && res.emit_prev, req_button_level)
   `BDLC_ASSERT_NEXT(a_push_shows, clock, reset, accept && (res.count != 2'd0), rsp_valid)

endmodule

### rtl/bdlc_core.sv
module bdlc_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           button_level,
   input  logic                           csr_we,
   input  logic [bdlc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdlc_pkg::CNT_W-1:0]     csr_wdata,
   output bdlc_pkg::tick_res_type         res
);

   logic [bdlc_pkg::CNT_W-1:0] lpt_ff, dwt_ff;
   logic                       prev_level_ff, prev_level_in;
   logic                       long_armed_ff, long_armed_in;
   logic [bdlc_pkg::CNT_W-1:0] long_elapsed_ff, long_elapsed_in;
   logic                       long_fired_ff, long_fired_in;
   logic                       release_seen_ff, release_seen_in;
   logic [bdlc_pkg::CNT_W-1:0] since_release_ff, since_release_in;
   logic                       tap_armed_ff, tap_armed_in;
   logic [bdlc_pkg::CNT_W-1:0] tap_elapsed_ff, tap_elapsed_in;
   logic [bdlc_pkg::CNT_W-1:0] sr_inc;
   logic                       rise, fall;
   logic                       emit_next, emit_pp, emit_prev;

   assign rise   = button_level & ~prev_level_ff;
   assign fall   = ~button_level & prev_level_ff;
   assign sr_inc = release_seen_ff ? bdlc_pkg::sat_inc(since_release_ff) : since_release_ff;

   always_comb begin
      prev_level_in    = button_level;
      long_armed_in    = long_armed_ff;
      long_elapsed_in  = long_armed_ff ? bdlc_pkg::sat_inc(long_elapsed_ff) : long_elapsed_ff;
      long_fired_in    = long_fired_ff;
      release_seen_in  = release_seen_ff;
      since_release_in = sr_inc;
      tap_armed_in     = tap_armed_ff;
      tap_elapsed_in   = tap_armed_ff ? bdlc_pkg::sat_inc(tap_elapsed_ff) : tap_elapsed_ff;
      emit_next        = 1'b0;
      emit_pp          = 1'b0;
      emit_prev        = 1'b0;

      if (rise) begin
         long_fired_in   = 1'b0;
         long_armed_in   = 1'b1;
         long_elapsed_in = '0;
      end else if (fall) begin
         long_armed_in = 1'b0;
         if (!long_fired_ff) begin
            if (release_seen_ff && (sr_inc <= dwt_ff)) begin
               tap_armed_in     = 1'b0;
               release_seen_in  = 1'b0;
               since_release_in = '0;
               emit_next        = 1'b1;
            end else begin
               release_seen_in  = 1'b1;
               since_release_in = '0;
               tap_armed_in     = 1'b1;
               tap_elapsed_in   = '0;
            end
         end
      end

      if (tap_armed_in && (tap_elapsed_in >= dwt_ff)) begin
         tap_armed_in = 1'b0;
         emit_pp      = 1'b1;
      end

      if (long_armed_in && (long_elapsed_in >= lpt_ff)) begin
         long_armed_in = 1'b0;
         if (button_level) begin
            long_fired_in = 1'b1;
            emit_prev     = 1'b1;
         end
      end
   end

   always_comb begin
      res.emit_pp     = emit_pp;
      res.emit_next   = emit_next;
      res.emit_prev   = emit_prev;
      res.count       = {1'b0, emit_pp | emit_next} + {1'b0, emit_prev};
      res.second.cmd  = bdlc_pkg::CMD_PREVIOUS;
      res.second.last = 1'b1;
      if (emit_pp || emit_next) begin
         res.first.cmd  = emit_next ? bdlc_pkg::CMD_NEXT : bdlc_pkg::CMD_PLAY_PAUSE;
         res.first.last = ~emit_prev;
      end else begin
         res.first.cmd  = bdlc_pkg::CMD_PREVIOUS;
         res.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lpt_ff <= bdlc_pkg::LONG_PRESS_RESET;
         dwt_ff <= bdlc_pkg::DOUBLE_WINDOW_RESET;
      end else if (csr_we) begin
         unique case (bdlc_pkg::csr_idx_type'(csr_index))
            bdlc_pkg::REG_LONG_PRESS:    lpt_ff <= csr_wdata;
            bdlc_pkg::REG_DOUBLE_WINDOW: dwt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff    <= 1'b0;
         long_armed_ff    <= 1'b0;
         long_elapsed_ff  <= '0;
         long_fired_ff    <= 1'b0;
         release_seen_ff  <= 1'b0;
         since_release_ff <= '0;
         tap_armed_ff     <= 1'b0;
         tap_elapsed_ff   <= '0;
      end else if (accept) begin
         prev_level_ff    <= prev_level_in;
         long_armed_ff    <= long_armed_in;
         long_elapsed_ff  <= long_elapsed_in;
         long_fired_ff    <= long_fired_in;
         release_seen_ff  <= release_seen_in;
         since_release_ff <= since_release_in;
         tap_armed_ff     <= tap_armed_in;
         tap_elapsed_ff   <= tap_elapsed_in;
      end
   end

endmodule

### rtl/bdlc_rsp_fifo.sv
module bdlc_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bdlc_pkg::tick_res_type res,
   input  logic                   pop,
   output bdlc_pkg::entry_type    head,
   output logic                   head_valid,
   output bdlc_pkg::fifo_stat_type stat
);

   bdlc_pkg::entry_type             mem_ff [bdlc_pkg::FIFO_DEPTH];
   logic [bdlc_pkg::PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [bdlc_pkg::LVL_W-1:0]      level_ff, level_in;
   logic [1:0]                      n_wr;
   logic                            do_pop;

   assign n_wr       = push ? res.count : 2'd0;
   assign head_valid = (level_ff != '0);
   assign do_pop     = pop & head_valid;
   assign head       = mem_ff[rd_ptr_ff];
   assign level_in   = level_ff + bdlc_pkg::LVL_W'(n_wr) - bdlc_pkg::LVL_W'(do_pop);

   assign stat.level    = level_ff;
   assign stat.has_room = (level_ff <= bdlc_pkg::LVL_W'(bdlc_pkg::FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) begin
         mem_ff[wr_ptr_ff] <= res.first;
      end
      if (n_wr == 2'd2) begin
         mem_ff[wr_ptr_ff + 1'b1] <= res.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + bdlc_pkg::PTR_W'(n_wr);
         rd_ptr_ff <= rd_ptr_ff + bdlc_pkg::PTR_W'(do_pop);
         level_ff  <= level_in;
      end
   end

endmodule
